// ===== src/segint_pkg.sv =====
// segint_pkg: shared constants, types and helpers for the segment intersection block
// used by every module under src; depends on nothing
package segint_pkg;

    // default datapath parameters
    localparam int COORD_WIDTH_DEF = 16;
    localparam int T_FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int PT_WIDTH   = 17;
    localparam int MIN_DEN_W  = 16;
    localparam int WRAP_W     = 64;

    // configuration port
    localparam int                    CFG_ADDR_W    = 2;
    localparam int                    CFG_DATA_W    = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MIN_DEN  = 2'd0;
    localparam logic [MIN_DEN_W-1:0]  MIN_DEN_RESET = 16'd7;

    // divider lanes
    localparam int NUM_LANES = 3;
    localparam int LANE_X    = 0;
    localparam int LANE_Y    = 1;
    localparam int LANE_T    = 2;

    // per-request status carried alongside the divider
    typedef struct packed {
        logic hit;
        logic neg_x;
        logic neg_y;
    } t_flags;

    function automatic int min_int(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== src/segint_cross.sv =====
// segint_cross: coordinate differences, six products and the three cross-product terms
// three register stages; depends on segint_pkg
module segint_cross
    import segint_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int DW = CW + 1,
    parameter int NW = min_int(2 * DW + 1, WRAP_W)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_ax,
    input  logic signed [CW-1:0] i_ay,
    input  logic signed [CW-1:0] i_bx,
    input  logic signed [CW-1:0] i_by,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    input  logic signed [CW-1:0] i_dx,
    input  logic signed [CW-1:0] i_dy,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [NW-1:0] o_tnum,
    output logic signed [NW-1:0] o_unum,
    output logic signed [NW-1:0] o_den,
    output logic signed [CW-1:0] o_ax,
    output logic signed [CW-1:0] o_ay,
    output logic signed [DW-1:0] o_gx,
    output logic signed [DW-1:0] o_gy
);

    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    logic signed [DW-1:0]   r_e1, r_e2, r_f1, r_f2, r_g1, r_g2;
    logic signed [CW-1:0]   r_ax1, r_ay1, r_ax2, r_ay2, r_ax3, r_ay3;
    logic signed [DW-1:0]   r_g1_2, r_g2_2, r_g1_3, r_g2_3;
    logic signed [2*DW-1:0] r_p_e1f2, r_p_e2f1, r_p_f2g1, r_p_f1g2, r_p_e2g1, r_p_e1g2;
    logic signed [2*DW:0]   n_tnum, n_unum, n_den;
    logic signed [NW-1:0]   r_tnum, r_unum, r_den;

    // bubble-collapsing stall chain
    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // stage 1: differences
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_e1  <= DW'(i_dx) - DW'(i_cx);
            r_e2  <= DW'(i_dy) - DW'(i_cy);
            r_f1  <= DW'(i_ax) - DW'(i_cx);
            r_f2  <= DW'(i_ay) - DW'(i_cy);
            r_g1  <= DW'(i_bx) - DW'(i_ax);
            r_g2  <= DW'(i_by) - DW'(i_ay);
            r_ax1 <= i_ax;
            r_ay1 <= i_ay;
        end
    end

    // stage 2: products
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_p_e1f2 <= r_e1 * r_f2;
            r_p_e2f1 <= r_e2 * r_f1;
            r_p_f2g1 <= r_f2 * r_g1;
            r_p_f1g2 <= r_f1 * r_g2;
            r_p_e2g1 <= r_e2 * r_g1;
            r_p_e1g2 <= r_e1 * r_g2;
            r_ax2    <= r_ax1;
            r_ay2    <= r_ay1;
            r_g1_2   <= r_g1;
            r_g2_2   <= r_g2;
        end
    end

    // stage 3: cross-product terms, wrapped to the working width
    always_comb begin
        n_tnum = (2*DW+1)'(r_p_e1f2) - (2*DW+1)'(r_p_e2f1);
        n_unum = (2*DW+1)'(r_p_f2g1) - (2*DW+1)'(r_p_f1g2);
        n_den  = (2*DW+1)'(r_p_e2g1) - (2*DW+1)'(r_p_e1g2);
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_tnum <= n_tnum[NW-1:0];
            r_unum <= n_unum[NW-1:0];
            r_den  <= n_den[NW-1:0];
            r_ax3  <= r_ax2;
            r_ay3  <= r_ay2;
            r_g1_3 <= r_g1_2;
            r_g2_3 <= r_g2_2;
        end
    end

    assign o_valid = r_v3;
    assign o_tnum  = r_tnum;
    assign o_unum  = r_unum;
    assign o_den   = r_den;
    assign o_ax    = r_ax3;
    assign o_ay    = r_ay3;
    assign o_gx    = r_g1_3;
    assign o_gy    = r_g2_3;

endmodule

// ===== src/segint_prep.sv =====
// segint_prep: sign normalization, range test and forming of the three dividends
// four register stages; depends on segint_pkg
module segint_prep
    import segint_pkg::*;
#(
    parameter int CW    = COORD_WIDTH_DEF,
    parameter int TB    = T_FRAC_BITS_DEF,
    parameter int DW    = CW + 1,
    parameter int NW    = min_int(2 * DW + 1, WRAP_W),
    parameter int PXW   = min_int(DW + NW, WRAP_W),
    parameter int TNUMW = min_int(NW - 1 + TB, WRAP_W),
    parameter int NUMW  = max_int(PXW, TNUMW) + 1,
    parameter int DENW  = NW - 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [MIN_DEN_W-1:0]                i_min_den,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [NW-1:0]                i_tnum,
    input  logic signed [NW-1:0]                i_unum,
    input  logic signed [NW-1:0]                i_den,
    input  logic signed [CW-1:0]                i_ax,
    input  logic signed [CW-1:0]                i_ay,
    input  logic signed [DW-1:0]                i_gx,
    input  logic signed [DW-1:0]                i_gy,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [NUM_LANES-1:0][NUMW-1:0]      o_num,
    output logic [DENW-1:0]                     o_den,
    output t_flags                              o_flags,
    output logic signed [CW-1:0]                o_ax,
    output logic signed [CW-1:0]                o_ay
);

    localparam int LOW  = (NW - 1) / 2;
    localparam int HIGH = NW - 1 - LOW;

    logic r_v4, r_v5, r_v6, r_v7;
    logic adv4, adv5, adv6, adv7;

    // stage 4 registers
    logic signed [NW-1:0] r_tn4, r_un4, r_dn4;
    logic signed [CW-1:0] r_ax4, r_ay4;
    logic signed [DW-1:0] r_gx4, r_gy4;
    // stage 5 registers
    logic                         r_hit5;
    logic signed [DW+LOW:0]       r_pxl, r_pyl;
    logic signed [DW+HIGH:0]      r_pxh, r_pyh;
    logic [NW-2:0]                r_tn5;
    logic [DENW-1:0]              r_dn5;
    logic signed [CW-1:0]         r_ax5, r_ay5;
    // stage 6 registers
    logic                         r_hit6;
    logic signed [PXW-1:0]        r_px, r_py;
    logic [TNUMW-1:0]             r_tsh;
    logic [DENW-1:0]              r_dn6;
    logic signed [CW-1:0]         r_ax6, r_ay6;
    // stage 7 registers
    logic [NUM_LANES-1:0][NUMW-1:0] r_num;
    logic [DENW-1:0]              r_dn7;
    t_flags                       r_flags;
    logic signed [CW-1:0]         r_ax7, r_ay7;

    logic                         n_neg;
    logic                         n_hit;
    logic signed [LOW:0]          n_tlo;
    logic signed [HIGH:0]         n_thi;
    logic signed [DW+NW-1:0]      n_sx, n_sy;
    logic [NW-2+TB:0]             n_tsh;
    logic [PXW-1:0]               n_magx, n_magy;

    // bubble-collapsing stall chain
    assign adv7    = !r_v7 || i_ready;
    assign adv6    = !r_v6 || adv7;
    assign adv5    = !r_v5 || adv6;
    assign adv4    = !r_v4 || adv5;
    assign o_ready = adv4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (adv4) r_v4 <= i_valid;
            if (adv5) r_v5 <= r_v4;
            if (adv6) r_v6 <= r_v5;
            if (adv7) r_v7 <= r_v6;
        end
    end

    // stage 4: make the denominator positive
    assign n_neg = i_den[NW-1];

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_tn4 <= n_neg ? -i_tnum : i_tnum;
            r_un4 <= n_neg ? -i_unum : i_unum;
            r_dn4 <= n_neg ? -i_den  : i_den;
            r_ax4 <= i_ax;
            r_ay4 <= i_ay;
            r_gx4 <= i_gx;
            r_gy4 <= i_gy;
        end
    end

    // stage 5: parallel and range test, split products for the point
    always_comb begin
        n_hit = !r_dn4[NW-1] && (r_dn4 != '0)
             && ($unsigned(r_dn4) > NW'(i_min_den))
             && !r_tn4[NW-1] && ($unsigned(r_tn4) <= $unsigned(r_dn4))
             && !r_un4[NW-1] && ($unsigned(r_un4) <= $unsigned(r_dn4));
        n_tlo = {1'b0, r_tn4[LOW-1:0]};
        n_thi = {1'b0, r_tn4[NW-2:LOW]};
    end

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r_hit5 <= n_hit;
            r_pxl  <= r_gx4 * n_tlo;
            r_pxh  <= r_gx4 * n_thi;
            r_pyl  <= r_gy4 * n_tlo;
            r_pyh  <= r_gy4 * n_thi;
            r_tn5  <= r_tn4[NW-2:0];
            r_dn5  <= r_dn4[DENW-1:0];
            r_ax5  <= r_ax4;
            r_ay5  <= r_ay4;
        end
    end

    // stage 6: join partial products, shift the t numerator
    always_comb begin
        n_sx  = ((DW+NW)'(r_pxh) <<< LOW) + (DW+NW)'(r_pxl);
        n_sy  = ((DW+NW)'(r_pyh) <<< LOW) + (DW+NW)'(r_pyl);
        n_tsh = {r_tn5, {TB{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (adv6) begin
            r_hit6 <= r_hit5;
            r_px   <= n_sx[PXW-1:0];
            r_py   <= n_sy[PXW-1:0];
            r_tsh  <= n_tsh[TNUMW-1:0];
            r_dn6  <= r_dn5;
            r_ax6  <= r_ax5;
            r_ay6  <= r_ay5;
        end
    end

    // stage 7: magnitudes for the unsigned divider
    always_comb begin
        n_magx = r_px[PXW-1] ? (~r_px + 1'b1) : r_px;
        n_magy = r_py[PXW-1] ? (~r_py + 1'b1) : r_py;
    end

    always_ff @(posedge i_clk) begin
        if (adv7) begin
            r_num[LANE_X] <= NUMW'(n_magx);
            r_num[LANE_Y] <= NUMW'(n_magy);
            r_num[LANE_T] <= NUMW'(r_tsh);
            r_dn7         <= r_dn6;
            r_flags.hit   <= r_hit6;
            r_flags.neg_x <= r_px[PXW-1];
            r_flags.neg_y <= r_py[PXW-1];
            r_ax7         <= r_ax6;
            r_ay7         <= r_ay6;
        end
    end

    assign o_valid = r_v7;
    assign o_num   = r_num;
    assign o_den   = r_dn7;
    assign o_flags = r_flags;
    assign o_ax    = r_ax7;
    assign o_ay    = r_ay7;

endmodule

// ===== src/segint_div.sv =====
// segint_div: pipelined restoring divider, one quotient bit per stage, shared divisor
// for all lanes; depends on segint_pkg
module segint_div
    import segint_pkg::*;
#(
    parameter int NUMW = 53,
    parameter int DENW = 34,
    parameter int QW   = 17,
    parameter int SBW  = 35
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [NUM_LANES-1:0][NUMW-1:0]  i_num,
    input  logic [DENW-1:0]                 i_den,
    input  logic [SBW-1:0]                  i_side,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [NUM_LANES-1:0][QW-1:0]    o_quo,
    output logic [NUM_LANES-1:0][DENW-1:0]  o_rem,
    output logic [SBW-1:0]                  o_side
);

    logic [QW-1:0]   r_v;
    logic [QW:0]     adv;
    logic [DENW-1:0] r_den [QW];
    logic [SBW-1:0]  r_sb  [QW];
    logic [DENW-1:0] r_rem [QW][NUM_LANES];
    logic [QW-1:0]   r_sh  [QW][NUM_LANES];

    assign adv[QW]  = i_ready;
    assign o_ready  = adv[0];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic            v_in;
        logic [DENW-1:0] den_in;
        logic [SBW-1:0]  sb_in;
        logic [DENW-1:0] rem_in [NUM_LANES];
        logic [QW-1:0]   sh_in  [NUM_LANES];
        logic [DENW-1:0] n_rem  [NUM_LANES];
        logic [QW-1:0]   n_sh   [NUM_LANES];

        assign adv[k] = !r_v[k] || adv[k+1];

        // stage input: the request, or the previous stage
        if (k == 0) begin : g_first
            always_comb begin
                logic [NUMW+DENW-1:0] ext;
                v_in   = i_valid;
                den_in = i_den;
                sb_in  = i_side;
                for (int l = 0; l < NUM_LANES; l++) begin
                    // upper dividend bits are below the divisor by range
                    ext       = {{DENW{1'b0}}, i_num[l]};
                    rem_in[l] = ext[QW +: DENW];
                    sh_in[l]  = i_num[l][QW-1:0];
                end
            end
        end else begin : g_next
            always_comb begin
                v_in   = r_v[k-1];
                den_in = r_den[k-1];
                sb_in  = r_sb[k-1];
                for (int l = 0; l < NUM_LANES; l++) begin
                    rem_in[l] = r_rem[k-1][l];
                    sh_in[l]  = r_sh[k-1][l];
                end
            end
        end

        // one restoring step per lane
        always_comb begin
            logic [DENW:0] trial;
            logic [DENW:0] diff;
            for (int l = 0; l < NUM_LANES; l++) begin
                trial = {rem_in[l], sh_in[l][QW-1]};
                diff  = trial - {1'b0, den_in};
                if (diff[DENW]) begin
                    n_rem[l] = trial[DENW-1:0];
                    n_sh[l]  = {sh_in[l][QW-2:0], 1'b0};
                end else begin
                    n_rem[l] = diff[DENW-1:0];
                    n_sh[l]  = {sh_in[l][QW-2:0], 1'b1};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (adv[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[k]) begin
                r_den[k] <= den_in;
                r_sb[k]  <= sb_in;
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_rem[k][l] <= n_rem[l];
                    r_sh[k][l]  <= n_sh[l];
                end
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_side  = r_sb[QW-1];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            o_quo[l] = r_sh[QW-1][l];
            o_rem[l] = r_rem[QW-1][l];
        end
    end

    // an empty last stage lets the whole chain move
    a_empty_tail_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[QW-1] |-> o_ready)
        else $error("divider stalls with an empty last stage");

endmodule

// ===== src/segment_intersection.sv =====
// segment_intersection: top level, stream ports, configuration register and output stage
// instantiates segint_cross, segint_prep and segint_div; depends on segint_pkg
//
// Tests two segments AB and CD given in signed Q8.8 and returns one result per request:
// hit, the crossing point and the Q1.16 position t along AB. The block is a fully
// pipelined datapath that takes one request every clock cycle while no stall holds it.
// From request to result, three stages form the cross products, four normalize and
// test them, QW stages of the long divider produce one quotient bit each (QW = 17 at
// the default widths), and one stage finishes the point.
// Stalls on the result side hold everything in place; empty stages still fill up, so the
// input keeps taking requests while a result waits. min_denominator sits at byte address
// 0 of the register port and must only be written while no request is in flight.
module segment_intersection
    import segint_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    localparam int IN_DW      = 8 * COORD_WIDTH,
    localparam int OUT_DW     = ((2 * COORD_WIDTH + PT_WIDTH + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DW-1:0]       s_axis_tdata,  // ax, ay, bx, by, cx, cy, dx, dy
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DW-1:0]      m_axis_tdata,  // cross_x, cross_y, param_t, zero pad
    output logic [0:0]             m_axis_tuser   // hit
);

    localparam int CW    = COORD_WIDTH;
    localparam int TB    = T_FRAC_BITS;
    localparam int DW    = CW + 1;
    localparam int NW    = min_int(2 * DW + 1, WRAP_W);
    localparam int PXW   = min_int(DW + NW, WRAP_W);
    localparam int QXY   = (DW + NW <= WRAP_W) ? DW : PXW;
    localparam int TNUMW = min_int(NW - 1 + TB, WRAP_W);
    localparam int TQW   = (NW - 1 + TB <= WRAP_W) ? TB + 1 : TNUMW;
    localparam int QW    = max_int(QXY, TQW);
    localparam int NUMW  = max_int(PXW, TNUMW) + 1;
    localparam int DENW  = NW - 1;
    localparam int FLW   = $bits(t_flags);
    localparam int SBW   = FLW + 2 * CW;

    // configuration register
    logic [MIN_DEN_W-1:0] r_min_den;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_DEN) ? CFG_DATA_W'(r_min_den) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_den <= MIN_DEN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_MIN_DEN)) begin
            r_min_den <= pwdata[MIN_DEN_W-1:0];
        end
    end

    // cross products
    logic                 cr_valid, cr_ready;
    logic signed [NW-1:0] cr_tnum, cr_unum, cr_den;
    logic signed [CW-1:0] cr_ax, cr_ay;
    logic signed [DW-1:0] cr_gx, cr_gy;

    segint_cross #(
        .CW (CW),
        .DW (DW),
        .NW (NW)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_ax    (s_axis_tdata[0*CW +: CW]),
        .i_ay    (s_axis_tdata[1*CW +: CW]),
        .i_bx    (s_axis_tdata[2*CW +: CW]),
        .i_by    (s_axis_tdata[3*CW +: CW]),
        .i_cx    (s_axis_tdata[4*CW +: CW]),
        .i_cy    (s_axis_tdata[5*CW +: CW]),
        .i_dx    (s_axis_tdata[6*CW +: CW]),
        .i_dy    (s_axis_tdata[7*CW +: CW]),
        .o_valid (cr_valid),
        .i_ready (cr_ready),
        .o_tnum  (cr_tnum),
        .o_unum  (cr_unum),
        .o_den   (cr_den),
        .o_ax    (cr_ax),
        .o_ay    (cr_ay),
        .o_gx    (cr_gx),
        .o_gy    (cr_gy)
    );

    // range test and dividends
    logic                           pp_valid, pp_ready;
    logic [NUM_LANES-1:0][NUMW-1:0] pp_num;
    logic [DENW-1:0]                pp_den;
    t_flags                         pp_flags;
    logic signed [CW-1:0]           pp_ax, pp_ay;

    segint_prep #(
        .CW    (CW),
        .TB    (TB),
        .DW    (DW),
        .NW    (NW),
        .PXW   (PXW),
        .TNUMW (TNUMW),
        .NUMW  (NUMW),
        .DENW  (DENW)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_min_den (r_min_den),
        .i_valid   (cr_valid),
        .o_ready   (cr_ready),
        .i_tnum    (cr_tnum),
        .i_unum    (cr_unum),
        .i_den     (cr_den),
        .i_ax      (cr_ax),
        .i_ay      (cr_ay),
        .i_gx      (cr_gx),
        .i_gy      (cr_gy),
        .o_valid   (pp_valid),
        .i_ready   (pp_ready),
        .o_num     (pp_num),
        .o_den     (pp_den),
        .o_flags   (pp_flags),
        .o_ax      (pp_ax),
        .o_ay      (pp_ay)
    );

    // divider
    logic                           dv_valid, dv_ready;
    logic [SBW-1:0]                 dv_side_in, dv_side_out;
    logic [NUM_LANES-1:0][QW-1:0]   dv_quo;
    logic [NUM_LANES-1:0][DENW-1:0] dv_rem;

    assign dv_side_in = {pp_flags, pp_ay, pp_ax};

    segint_div #(
        .NUMW (NUMW),
        .DENW (DENW),
        .QW   (QW),
        .SBW  (SBW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pp_valid),
        .o_ready (pp_ready),
        .i_num   (pp_num),
        .i_den   (pp_den),
        .i_side  (dv_side_in),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_quo   (dv_quo),
        .o_rem   (dv_rem),
        .o_side  (dv_side_out)
    );

    // output stage: floor correction and point
    t_flags                    fl;
    logic [CW-1:0]             dv_ax, dv_ay;
    logic [CW-1:0]             qx, qy;
    logic                      nzx, nzy;
    logic [QW+PT_WIDTH-1:0]    pt_ext;
    logic [CW-1:0]             n_cx, n_cy;
    logic [PT_WIDTH-1:0]       n_pt;
    logic                      r_out_v;
    logic                      r_hit;
    logic [CW-1:0]             r_cx, r_cy;
    logic [PT_WIDTH-1:0]       r_pt;

    assign fl       = t_flags'(dv_side_out[SBW-1 -: FLW]);
    assign dv_ay    = dv_side_out[CW +: CW];
    assign dv_ax    = dv_side_out[0 +: CW];
    assign dv_ready = !r_out_v || m_axis_tready;

    always_comb begin
        qx     = dv_quo[LANE_X][CW-1:0];
        qy     = dv_quo[LANE_Y][CW-1:0];
        nzx    = |dv_rem[LANE_X];
        nzy    = |dv_rem[LANE_Y];
        pt_ext = {{PT_WIDTH{1'b0}}, dv_quo[LANE_T]};
        n_cx   = '0;
        n_cy   = '0;
        n_pt   = '0;
        if (fl.hit) begin
            n_cx = fl.neg_x ? (dv_ax - qx - CW'(nzx)) : (dv_ax + qx);
            n_cy = fl.neg_y ? (dv_ay - qy - CW'(nzy)) : (dv_ay + qy);
            n_pt = pt_ext[PT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (dv_ready) begin
            r_out_v <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_ready) begin
            r_hit <= fl.hit;
            r_cx  <= n_cx;
            r_cy  <= n_cy;
            r_pt  <= n_pt;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_hit;
    assign m_axis_tdata  = OUT_DW'({r_pt, r_cy, r_cx});

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("miss result with nonzero payload");

    // with the output register free, the request side is never held off
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request stalled with an empty output stage");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for segment_intersection, stream requests in and results out
// predicts every result in-line and compares field by field; depends on segint_pkg and src RTL
module tb_top
    import segint_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int IN_DW       = 8 * CW;
    localparam int OUT_DW      = ((2 * CW + PT_WIDTH + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 320;
    localparam int NUM_DIRECTED = 19;

    // request fields, ax in the lowest bits so the struct maps straight onto tdata
    typedef struct packed {
        logic [CW-1:0] dy;
        logic [CW-1:0] dx;
        logic [CW-1:0] cy;
        logic [CW-1:0] cx;
        logic [CW-1:0] by;
        logic [CW-1:0] bx;
        logic [CW-1:0] ay;
        logic [CW-1:0] ax;
    } seg_pair_t;

    typedef struct packed {
        logic                hit;
        logic [CW-1:0]       cross_x;
        logic [CW-1:0]       cross_y;
        logic [PT_WIDTH-1:0] param_t;
    } crossing_t;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DW-1:0]      s_axis_tdata = '0;   // ax, ay, bx, by, cx, cy, dx, dy
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]     m_axis_tdata;        // cross_x, cross_y, param_t, zero pad
    logic [0:0]            m_axis_tuser;        // hit

    seg_pair_t      pending_pairs[$];
    crossing_t      expected_crossings[$];
    seg_pair_t      offered_pair;
    logic [15:0]    min_den_cfg = MIN_DEN_RESET;
    int             queued_total = 0;
    int             results_total = 0;
    int             mismatches = 0;
    int             cycle_count = 0;
    int             src_gap = 0;
    int             sink_stall = 0;
    bit             src_idle_on = 1'b1;
    bit             sink_idle_on = 1'b1;
    bit             hold_go = 1'b0;
    logic           sink_hold = 1'b0;

    // hand-picked segment pairs: ax, ay, bx, by, cx, cy, dx, dy (raw Q8.8 counts)
    int directed_cases [NUM_DIRECTED][8] = '{
        '{-256, -256, 256, 256, -256, 256, 256, -256},          // plain crossing, t = 0.5
        '{-256, -256, 256, 256, 256, -256, -256, 256},          // same with positive denominator
        '{0, 0, 8, 0, 4, -1, 4, 0},                             // |den| one above the threshold
        '{0, 0, 7, 0, 3, -1, 3, 0},                             // |den| equal to the threshold
        '{0, 0, 100, 100, 0, 10, 100, 110},                     // parallel
        '{0, 0, 100, 0, 50, 0, 200, 0},                         // collinear overlap
        '{0, 0, 100, 0, 0, -50, 0, 50},                         // crossing at t = 0
        '{0, 0, 100, 0, 100, -50, 100, 50},                     // crossing at t = 1
        '{0, 0, 100, 0, 50, 0, 50, 50},                         // crossing at u = 0
        '{0, 0, 100, 0, 101, -50, 101, 50},                     // just past the end of AB
        '{0, 0, 100, 0, 50, 10, 50, 60},                        // u below zero
        '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
        '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
        '{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767},
        '{0, 0, -3, -7, -3, 0, 0, -7},                          // negative point, floored
        '{-1, -1, 2, 5, 2, -1, -1, 5},
        '{0, 0, 10, 10, 10, 10, 20, 0},                         // shared endpoint B = C
        '{5, 5, 5, 5, 0, 0, 10, 10}                             // zero-length AB
    };

    segment_intersection dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor division for a positive divisor
    function automatic longint floor_quot(longint n, longint d);
        longint q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    // expected result of one segment pair under the given parallel threshold
    function automatic crossing_t predict_crossing(seg_pair_t p, logic [15:0] min_den);
        longint ax = longint'($signed(p.ax));
        longint ay = longint'($signed(p.ay));
        longint bx = longint'($signed(p.bx));
        longint by = longint'($signed(p.by));
        longint cx = longint'($signed(p.cx));
        longint cy = longint'($signed(p.cy));
        longint dx = longint'($signed(p.dx));
        longint dy = longint'($signed(p.dy));
        longint tnum, unum, den;
        crossing_t r = '0;
        tnum = (dx - cx) * (ay - cy) - (dy - cy) * (ax - cx);
        unum = (cy - ay) * (ax - bx) - (cx - ax) * (ay - by);
        den  = (dy - cy) * (bx - ax) - (dx - cx) * (by - ay);
        // flip signs so the denominator is positive
        if (den < 0) begin
            den  = -den;
            tnum = -tnum;
            unum = -unum;
        end
        if (den > longint'(min_den) && tnum >= 0 && tnum <= den && unum >= 0 && unum <= den) begin
            r.hit     = 1'b1;
            r.cross_x = CW'(ax + floor_quot((bx - ax) * tnum, den));
            r.cross_y = CW'(ay + floor_quot((by - ay) * tnum, den));
            r.param_t = PT_WIDTH'((tnum <<< T_FRAC_BITS_DEF) / den);
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] clamp_coord(int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return CW'(v);
    endfunction

    function automatic int rand_offset(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic seg_pair_t seg_from_coords(input int c [8]);
        seg_pair_t p;
        p.ax = clamp_coord(c[0]);
        p.ay = clamp_coord(c[1]);
        p.bx = clamp_coord(c[2]);
        p.by = clamp_coord(c[3]);
        p.cx = clamp_coord(c[4]);
        p.cy = clamp_coord(c[5]);
        p.dx = clamp_coord(c[6]);
        p.dy = clamp_coord(c[7]);
        return p;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random pair: raw noise, tight clusters, built crossings, parallel and shared ends
    function automatic seg_pair_t random_pair();
        int c [8];
        int sel, w, k, j, s, mx, my, ox, oy, base_x, base_y;
        seg_pair_t p;
        sel = $urandom_range(0, 9);
        if (sel <= 2) begin
            p = {$urandom, $urandom, $urandom, $urandom};
            return p;
        end
        if (sel <= 4) begin
            // small cluster, denominators near the threshold
            w = $urandom_range(1, 40);
            base_x = rand_offset(16000);
            base_y = rand_offset(16000);
            for (int i = 0; i < 8; i++) c[i] = ((i % 2) != 0 ? base_y : base_x) + rand_offset(w);
        end else begin
            for (int i = 0; i < 4; i++) c[i] = rand_offset(16384);
            if (sel <= 8) begin
                // CD passes through a point of AB, boundaries at k = 0, 8 and j = 0
                k = $urandom_range(0, 8);
                j = $urandom_range(0, 8);
                mx = c[0] + (c[2] - c[0]) * k / 8;
                my = c[1] + (c[3] - c[1]) * k / 8;
                ox = rand_offset(8192);
                oy = rand_offset(8192);
                c[4] = mx + ox;
                c[5] = my + oy;
                c[6] = mx - ox * j / 4;
                c[7] = my - oy * j / 4;
            end else if ($urandom_range(0, 1) != 0) begin
                // CD parallel to AB, either direction
                s = $urandom_range(0, 3);
                c[4] = rand_offset(8192);
                c[5] = rand_offset(8192);
                c[6] = c[4] + (($urandom_range(0, 1) != 0) ? 1 : -1) * ((c[2] - c[0]) >>> s);
                c[7] = c[5] + (((c[6] - c[4]) * (c[2] - c[0]) >= 0) ? 1 : -1) * ((c[3] - c[1]) >>> s);
                if ($urandom_range(0, 3) == 0) begin
                    c[4] = c[0];
                    c[5] = c[1];
                end
            end else begin
                // CD starts at an endpoint of AB
                k = ($urandom_range(0, 1) != 0) ? 2 : 0;
                c[4] = c[k];
                c[5] = c[k + 1];
                c[6] = rand_offset(16384);
                c[7] = rand_offset(16384);
            end
        end
        return seg_from_coords(c);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatches < 40)
            $display("mismatch %s at result %0d: got 0x%0h expected 0x%0h",
                     what, results_total, got, want);
        mismatches++;
    endtask

    task automatic queue_pair(seg_pair_t p);
        pending_pairs.push_back(p);
        queued_total++;
    endtask

    task automatic wait_drained();
        while (results_total != queued_total) @(posedge i_clk);
    endtask

    task automatic read_register(input logic [CFG_ADDR_W-1:0] addr,
                                 output logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // request driver: offers queued pairs, predicts each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_crossings.push_back(predict_crossing(offered_pair, min_den_cfg));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    offered_pair = pending_pairs.pop_front();
                    s_axis_tdata  <= offered_pair;
                    s_axis_tvalid <= 1'b1;
                    if (src_idle_on && $urandom_range(0, 99) < 30) src_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks against the oldest prediction, drives ready with stalls
    always @(posedge i_clk) begin
        crossing_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_crossings.size() == 0) begin
                    report_mismatch("unexpected result", longint'(m_axis_tdata), 0);
                end else begin
                    want = expected_crossings.pop_front();
                    if (m_axis_tuser[0] !== want.hit)
                        report_mismatch("hit", longint'(m_axis_tuser), longint'(want.hit));
                    if (m_axis_tdata[CW-1:0] !== want.cross_x)
                        report_mismatch("cross_x", longint'(m_axis_tdata[CW-1:0]),
                                        longint'(want.cross_x));
                    if (m_axis_tdata[2*CW-1:CW] !== want.cross_y)
                        report_mismatch("cross_y", longint'(m_axis_tdata[2*CW-1:CW]),
                                        longint'(want.cross_y));
                    if (m_axis_tdata[2*CW+PT_WIDTH-1:2*CW] !== want.param_t)
                        report_mismatch("param_t", longint'(m_axis_tdata[2*CW+PT_WIDTH-1:2*CW]),
                                        longint'(want.param_t));
                    results_total++;
                end
            end
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 99) < 20) begin
                sink_stall = pick_gap() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the pipeline fills and back-pressures the input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus sequence: directed pairs at the reset threshold, then random phases
    initial begin
        logic [15:0]           cfg_val;
        logic [CFG_DATA_W-1:0] rd;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_register(ADDR_MIN_DEN, rd);
        if (rd !== {16'h0, min_den_cfg})
            report_mismatch("min_denominator after reset", longint'(rd), longint'(min_den_cfg));

        for (int i = 0; i < NUM_DIRECTED; i++) queue_pair(seg_from_coords(directed_cases[i]));
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: cfg_val = 16'd0;
                1: cfg_val = 16'hFFFF;
                3: cfg_val = 16'd1;
                4: cfg_val = MIN_DEN_RESET;
                default: cfg_val = 16'($urandom);
            endcase
            // register write, junk in the upper data bits
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_MIN_DEN;
            pwdata  <= {16'($urandom), cfg_val};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            min_den_cfg = cfg_val;
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
            read_register(ADDR_MIN_DEN, rd);
            if (rd !== {16'h0, min_den_cfg})
                report_mismatch("min_denominator readback", longint'(rd), longint'(min_den_cfg));

            src_idle_on  = (ph != 1 && ph != 2);
            sink_idle_on = (ph != 2 && ph != 3);
            if (ph == 1) hold_go = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) queue_pair(random_pair());
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
